### rtl/core/first_fit_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator
// Immediate-cycle and next-cycle implication checks, removable at compile time.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FFBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FFBA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Request, response and table entry types, state encoding, codes and sizing constants.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int AddrBits      = 16;
	localparam int SizeBits      = AddrBits + 1;
	localparam int MaxBlocksDflt = 64;
	localparam logic [SizeBits-1:0] CapMax = SizeBits'(1) << AddrBits;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_ZERO   = 2'd2,
		ST_BADOFF = 2'd3
	} status_t;

	typedef struct packed {
		logic                kind;
		logic [SizeBits-1:0] alloc_size;
		logic [AddrBits-1:0] release_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [AddrBits-1:0] offset;
	} rsp_t;

	typedef struct packed {
		logic [AddrBits-1:0] start;
		logic [SizeBits-1:0] size;
		logic                used;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SC_RD, S_SC_CK, S_SP_RD, S_SP_WR, S_SP_W1, S_SP_W2,
		S_RL_RD, S_RL_CK, S_MG1, S_MG2, S_CL_ST, S_CL_WR
	} fsm_t;

endpackage

### rtl/core/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// First-fit block allocator
// Keeps an address-ordered block table in a single-port-write memory and
// serves allocate and release requests by walking it with one comparator.
// ----------------------------------------------------------------------------
// A zero-size allocate is answered from idle; otherwise each entry walked is
// read and then checked, entries are moved one at a time on a split or merge,
// and the response comes when the walk or the move ends.
// One request at a time; busy is high meanwhile.
// The table memory port sets the pace of this walk. Reset and a capacity write
// rebuild the table as one free block in S_INIT; the receiver cannot stall.
`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int MAX_BLOCKS = MaxBlocksDflt
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [SizeBits-1:0] cfg_wr_data,
	input  logic                start,
	input  req_t                req,
	output logic                busy,
	output logic                done,
	output rsp_t                rsp
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKS);

	entry_t mem [MAX_BLOCKS];
	entry_t rd_q;

	fsm_t state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [CW-1:0] cnt_q, cnt_d, k_q, k_d;
	logic [1:0] r_q, r_d;
	logic [SizeBits-1:0] cap_q, req_size_q, req_size_d, acc_q, acc_d, nsize_q, nsize_d;
	logic [AddrBits-1:0] addr_q, addr_d;
	logic kind_q, kind_d, nfree_q, nfree_d, pfree_q, pfree_d;
	entry_t hit_q, hit_d, prev_q, prev_d;
	logic done_q, done_d;
	rsp_t rsp_q, rsp_d;

	logic we;
	logic [IW-1:0] wa, ra;
	entry_t wd;
	logic [CW-1:0] idx_p1;
	logic [SizeBits-1:0] cap_sat;

	assign idx_p1 = {1'b0, idx_q} + CW'(1);
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_sat = SizeBits'(1);
		end else if (cfg_wr_data > CapMax) begin
			cap_sat = CapMax;
		end else begin
			cap_sat = cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cap_q   <= CapMax;
			cnt_q   <= CW'(1);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				cap_q <= cap_sat;
			end
			cnt_q  <= cnt_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		k_q        <= k_d;
		r_q        <= r_d;
		req_size_q <= req_size_d;
		acc_q      <= acc_d;
		nsize_q    <= nsize_d;
		addr_q     <= addr_d;
		kind_q     <= kind_d;
		nfree_q    <= nfree_d;
		pfree_q    <= pfree_d;
		hit_q      <= hit_d;
		prev_q     <= prev_d;
		rsp_q      <= rsp_d;
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		k_d        = k_q;
		r_d        = r_q;
		req_size_d = req_size_q;
		acc_d      = acc_q;
		nsize_d    = nsize_q;
		addr_d     = addr_q;
		kind_d     = kind_q;
		nfree_d    = nfree_q;
		pfree_d    = pfree_q;
		hit_d      = hit_q;
		prev_d     = prev_q;
		cnt_d      = cnt_q;
		done_d     = 1'b0;
		rsp_d      = rsp_q;
		we         = 1'b0;
		wa         = idx_q;
		wd         = rd_q;
		ra         = idx_q;
		unique case (state_q)
			S_INIT: begin
				we       = 1'b1;
				wa       = '0;
				wd.start = '0;
				wd.size  = cap_q;
				wd.used  = 1'b0;
				cnt_d    = CW'(1);
				state_d  = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_wr_en) begin
					state_d = S_INIT;
				end else if (start) begin
					kind_d     = req.kind;
					req_size_d = req.alloc_size;
					addr_d     = req.release_offset;
					idx_d      = '0;
					if (req.kind == KIND_ALLOC && req.alloc_size == '0) begin
						done_d = 1'b1;
						rsp_d  = '{status: ST_ZERO, offset: '0};
					end else begin
						state_d = S_SC_RD;
					end
				end
			end
			S_SC_RD: begin
				ra      = idx_q;
				state_d = S_SC_CK;
			end
			S_SC_CK: begin
				if (kind_q == KIND_ALLOC) begin
					if (!rd_q.used && rd_q.size >= req_size_q) begin
						if (rd_q.size == req_size_q) begin
							we      = 1'b1;
							wa      = idx_q;
							wd      = rd_q;
							wd.used = 1'b1;
							done_d  = 1'b1;
							rsp_d   = '{status: ST_OK, offset: rd_q.start};
							state_d = S_IDLE;
						end else if (cnt_q >= MaxCnt) begin
							done_d  = 1'b1;
							rsp_d   = '{status: ST_NOFIT, offset: '0};
							state_d = S_IDLE;
						end else begin
							hit_d   = rd_q;
							k_d     = cnt_q;
							state_d = (cnt_q > idx_p1) ? S_SP_RD : S_SP_W1;
						end
					end else if (idx_p1 >= cnt_q) begin
						done_d  = 1'b1;
						rsp_d   = '{status: ST_NOFIT, offset: '0};
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_p1[IW-1:0];
						state_d = S_SC_RD;
					end
				end else begin
					if (rd_q.start == addr_q) begin
						if (!rd_q.used) begin
							done_d  = 1'b1;
							rsp_d   = '{status: ST_BADOFF, offset: '0};
							state_d = S_IDLE;
						end else begin
							hit_d   = rd_q;
							pfree_d = (idx_q != '0) && !prev_q.used;
							nfree_d = 1'b0;
							nsize_d = '0;
							state_d = (idx_p1 < cnt_q) ? S_RL_RD : S_MG1;
						end
					end else if (idx_p1 >= cnt_q) begin
						done_d  = 1'b1;
						rsp_d   = '{status: ST_BADOFF, offset: '0};
						state_d = S_IDLE;
					end else begin
						prev_d  = rd_q;
						idx_d   = idx_p1[IW-1:0];
						state_d = S_SC_RD;
					end
				end
			end
			S_SP_RD: begin
				ra      = IW'(k_q - CW'(1));
				state_d = S_SP_WR;
			end
			S_SP_WR: begin
				we      = 1'b1;
				wa      = k_q[IW-1:0];
				wd      = rd_q;
				k_d     = k_q - CW'(1);
				state_d = ((k_q - CW'(1)) > idx_p1) ? S_SP_RD : S_SP_W1;
			end
			S_SP_W1: begin
				we       = 1'b1;
				wa       = idx_p1[IW-1:0];
				wd.start = hit_q.start + req_size_q[AddrBits-1:0];
				wd.size  = hit_q.size - req_size_q;
				wd.used  = 1'b0;
				state_d  = S_SP_W2;
			end
			S_SP_W2: begin
				we       = 1'b1;
				wa       = idx_q;
				wd.start = hit_q.start;
				wd.size  = req_size_q;
				wd.used  = 1'b1;
				cnt_d    = cnt_q + CW'(1);
				done_d   = 1'b1;
				rsp_d    = '{status: ST_OK, offset: hit_q.start};
				state_d  = S_IDLE;
			end
			S_RL_RD: begin
				ra      = idx_p1[IW-1:0];
				state_d = S_RL_CK;
			end
			S_RL_CK: begin
				nfree_d = !rd_q.used;
				nsize_d = rd_q.size;
				state_d = S_MG1;
			end
			S_MG1: begin
				acc_d   = hit_q.size + (nfree_q ? nsize_q : '0);
				state_d = S_MG2;
			end
			S_MG2: begin
				we       = 1'b1;
				wa       = pfree_q ? (idx_q - IW'(1)) : idx_q;
				wd.start = pfree_q ? prev_q.start : hit_q.start;
				wd.size  = (pfree_q ? prev_q.size : '0) + acc_q;
				wd.used  = 1'b0;
				k_d      = {1'b0, wa} + CW'(1);
				r_d      = {1'b0, nfree_q} + {1'b0, pfree_q};
				rsp_d    = '{status: ST_OK, offset: wd.start};
				state_d  = S_CL_ST;
			end
			S_CL_ST: begin
				ra = IW'(k_q + CW'(r_q));
				if (r_q != '0 && (k_q + CW'(r_q)) < cnt_q) begin
					state_d = S_CL_WR;
				end else begin
					cnt_d   = cnt_q - CW'(r_q);
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_CL_WR: begin
				we      = 1'b1;
				wa      = k_q[IW-1:0];
				wd      = rd_q;
				k_d     = k_q + CW'(1);
				state_d = S_CL_ST;
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	`FFBA_ASSERT_SAME(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
	`FFBA_ASSERT_SAME(a_cnt_range, clk, arst_n, 1'b1, cnt_q != '0 && cnt_q <= MaxCnt)
	`FFBA_ASSERT_SAME(a_err_off, clk, arst_n, done_q && rsp_q.status != ST_OK, rsp_q.offset == '0)
	`FFBA_ASSERT_NEXT(a_accept, clk, arst_n, start && !busy && !cfg_wr_en, busy || done_q)

endmodule

### test/first_fit_block_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit block allocator testbench
// Drives allocate and release requests through the start/busy handshake and
// checks every response against a block-table predictor held in a scoreboard.
// Several capacities are written, including the range extremes.
// ----------------------------------------------------------------------------

module first_fit_block_allocator_test
	import ffba_pkg::*;
;

	class alloc_scoreboard;
		int unsigned blk_start[64];
		int unsigned blk_size[64];
		bit          blk_used[64];
		int unsigned blk_count;
		rsp_t        pending[$];
		int unsigned errors;

		function void set_capacity(int unsigned value);
			if (value == 0)
				value = 1;
			if (value > 65536)
				value = 65536;
			foreach (blk_start[i]) begin
				blk_start[i] = 0;
				blk_size[i] = 0;
				blk_used[i] = 0;
			end
			blk_size[0] = value;
			blk_count = 1;
		endfunction

		function void drop_entry(int unsigned i);
			for (int unsigned k = i; k + 1 < blk_count; k++) begin
				blk_start[k] = blk_start[k + 1];
				blk_size[k] = blk_size[k + 1];
				blk_used[k] = blk_used[k + 1];
			end
			blk_count--;
			blk_start[blk_count] = 0;
			blk_size[blk_count] = 0;
			blk_used[blk_count] = 0;
		endfunction

		function rsp_t allocate(int unsigned amount);
			rsp_t r;
			r.status = ST_NOFIT;
			r.offset = '0;
			if (amount == 0) begin
				r.status = ST_ZERO;
				return r;
			end
			for (int unsigned i = 0; i < blk_count; i++) begin
				if (blk_used[i] || blk_size[i] < amount)
					continue;
				if (blk_size[i] == amount) begin
					blk_used[i] = 1;
					r.status = ST_OK;
					r.offset = AddrBits'(blk_start[i]);
					return r;
				end
				if (blk_count >= 64)
					return r;
				for (int unsigned k = blk_count; k > i + 1; k--) begin
					blk_start[k] = blk_start[k - 1];
					blk_size[k] = blk_size[k - 1];
					blk_used[k] = blk_used[k - 1];
				end
				blk_count++;
				blk_start[i + 1] = blk_start[i] + amount;
				blk_size[i + 1] = blk_size[i] - amount;
				blk_used[i + 1] = 0;
				blk_size[i] = amount;
				blk_used[i] = 1;
				r.status = ST_OK;
				r.offset = AddrBits'(blk_start[i]);
				return r;
			end
			return r;
		endfunction

		function rsp_t release_block(int unsigned addr);
			rsp_t r;
			int unsigned i;
			r.status = ST_BADOFF;
			r.offset = '0;
			for (i = 0; i < blk_count; i++)
				if (blk_start[i] == addr)
					break;
			if (i >= blk_count || !blk_used[i])
				return r;
			blk_used[i] = 0;
			if (i + 1 < blk_count && !blk_used[i + 1]) begin
				blk_size[i] += blk_size[i + 1];
				drop_entry(i + 1);
			end
			if (i > 0 && !blk_used[i - 1]) begin
				blk_size[i - 1] += blk_size[i];
				drop_entry(i);
				i--;
			end
			r.status = ST_OK;
			r.offset = AddrBits'(blk_start[i]);
			return r;
		endfunction

		function int pick_used_start();
			int unsigned idx[$];
			for (int unsigned i = 0; i < blk_count; i++)
				if (blk_used[i])
					idx.push_back(i);
			if (idx.size() == 0)
				return -1;
			return int'(blk_start[idx[$urandom_range(0, idx.size() - 1)]]);
		endfunction

		function void note_request(req_t rq);
			if (rq.kind == KIND_ALLOC)
				pending.push_back(allocate(32'(rq.alloc_size)));
			else
				pending.push_back(release_block(32'(rq.release_offset)));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$error("response with no request outstanding: status %0d offset %0d",
					got.status, got.offset);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.offset !== want.offset) begin
				$error("offset: expected %0d, actual %0d", want.offset, got.offset);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [SizeBits-1:0] cfg_wr_data;
	logic                start;
	req_t                req;
	logic                busy;
	logic                done;
	rsp_t                rsp;

	alloc_scoreboard     sb;
	int unsigned         idle_cycles;
	int unsigned         burst_left;
	bit                  accepted;

	first_fit_block_allocator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (start),
		.req         (req),
		.busy        (busy),
		.done        (done),
		.rsp         (rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		accepted = start && !busy && arst_n;
		if (arst_n && done)
			sb.check_response(rsp);
		if (accepted || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 5000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send(input req_t rq);
		if (burst_left == 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		start <= 1'b1;
		req <= rq;
		do
			@(posedge clk);
		while (busy);
		sb.note_request(rq);
	endtask

	task automatic alloc_req(input int unsigned amount);
		req_t rq;
		rq.kind = KIND_ALLOC;
		rq.alloc_size = SizeBits'(amount);
		rq.release_offset = AddrBits'($urandom);
		send(rq);
	endtask

	task automatic release_req(input int unsigned addr);
		req_t rq;
		rq.kind = KIND_RELEASE;
		rq.alloc_size = SizeBits'($urandom);
		rq.release_offset = AddrBits'(addr);
		send(rq);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_capacity(input int unsigned value);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= SizeBits'(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_capacity(value);
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic random_phase(input int unsigned count, input int unsigned cap);
		int addr;
		int unsigned pick;
		for (int unsigned n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				case ($urandom_range(0, 9))
					0: alloc_req($urandom_range(0, 131071));
					1: alloc_req(0);
					2: alloc_req($urandom_range(1, cap));
					default: alloc_req($urandom_range(1, (cap + 63) / 64 + 1));
				endcase
			end else if (pick < 90) begin
				addr = sb.pick_used_start();
				release_req(addr < 0 ? $urandom_range(0, 65535) : addr);
			end else begin
				release_req($urandom_range(0, 65535));
			end
		end
	endtask

	initial begin
		int unsigned caps[10];
		sb = new();
		sb.set_capacity(65536);
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		start = 1'b0;
		req = '0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		alloc_req(0);
		alloc_req(65536);
		alloc_req(1);
		release_req(0);
		release_req(0);
		alloc_req(65537);
		alloc_req(131071);
		release_req(12345);
		release_req(65535);
		alloc_req(100);
		alloc_req(200);
		alloc_req(300);
		release_req(100);
		release_req(0);
		release_req(300);
		alloc_req(65536);
		drain();

		write_capacity(200);
		for (int unsigned n = 0; n < 66; n++)
			alloc_req(1);
		alloc_req(200);
		drain();

		caps = '{0, 1, 131071, 65536, 100000, 64, 300, 4096, 65535, 1000};
		foreach (caps[c]) begin
			write_capacity(caps[c]);
			random_phase(110, sb.blk_size[0]);
		end
		drain();
		repeat (200) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
